// ===== sv/pca_pkg.sv =====
// shared types and constants for the predicted crossings accumulator
`default_nettype none

package pca_pkg;

  // fixed field widths
  localparam int POS_W = 16;
  localparam int SUM_W = 64;
  localparam int NV_W  = 17;

  // one input transaction
  typedef struct packed {
    logic [POS_W-1:0] pos_a1;
    logic [POS_W-1:0] pos_a2;
    logic [POS_W-1:0] pos_b1;
    logic [POS_W-1:0] pos_b2;
    logic             last_pair;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [SUM_W-1:0] expected_crossings;
    logic             zero_denominator_seen;
  } out_item_t;

  // main sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DRAIN,
    S_CHECK,
    S_DIV,
    S_ADD
  } state_t;

  // product steps issued to the shared multiplier
  typedef enum logic [2:0] {
    P_ALPHA_MAIN,
    P_ALPHA_SQ,
    P_BETA_HEAD,
    P_BETA_MID,
    P_BETA_TAIL,
    P_BETA_LAST
  } prod_step_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== sv/pca_divider.sv =====
// radix-2 restoring divider producing a saturating fixed-point quotient
`default_nettype none

module pca_divider import pca_pkg::*; #(
  parameter int AW            = 51,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    dividend,
  input  wire logic [AW-1:0]    divisor,
  output div_status_t           status,
  output logic      [SUM_W-1:0] quotient
);

  localparam int IW    = SUM_W - FRACTION_BITS;
  localparam int DW    = AW + SUM_W;
  localparam int CW    = AW + IW;
  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    rem;
  logic [AW-1:0]    dvs;
  logic [SUM_W-1:0] qd;
  logic [DW-1:0]    dfull;
  logic             overflow;
  logic [AW:0]      trial;
  logic             fits;

  // scaled dividend and integer part overflow test
  assign dfull    = DW'(dividend) << FRACTION_BITS;
  assign overflow = CW'(dividend) >= {divisor, {IW{1'b0}}};

  // one quotient bit per cycle
  assign trial = {rem, qd[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (overflow) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(SUM_W - 1);
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      if (overflow) begin
        qd <= '1;
      end else begin
        rem <= dfull[SUM_W +: AW];
        qd  <= dfull[SUM_W-1:0];
      end
    end else if (busy) begin
      rem <= fits ? AW'(trial - {1'b0, dvs}) : trial[AW-1:0];
      qd  <= {qd[SUM_W-2:0], fits};
    end
  end

  assign status   = '{busy: busy, done: done};
  assign quotient = qd;

endmodule

`default_nettype wire

// ===== sv/predicted_crossings_accumulator_core.sv =====
// Predicted crossings accumulator: per edge pair alpha/beta term, summed in fixed point.
//
// Input channel in_valid/in_stall/in_data carries one edge pair per transaction.
// The block takes one pair at a time: in_stall is high from the cycle after a
// pair is taken until its term has been added: setup, 6 products through the
// one shared multiplier, a drain step, a check, the one-bit-per-cycle
// restoring divider and its done step, then the add. A term whose integer
// part overflows skips the divider iterations, and a pair with no positive
// beta skips the divider.
// Output channel out_valid/out_stall/out_data carries the sum and the zero beta
// flag, once per pair marked last; sum and flag then clear. The result sits in
// an output register, so the next pair is taken while it waits; only a second
// last pair waits in its add cycle while out_stall holds the earlier result.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the vertex count;
// it is always ready and is meant to be written while the block is idle.
// Reset (rst, synchronous) clears the sum, the flag and the output valid and
// sets the vertex count to 2.
`default_nettype none

module predicted_crossings_accumulator_core import pca_pkg::*; #(
  parameter int MAX_VERTICES  = 65536,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [NV_W-1:0] cfg_data
);

  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int CMW = ((NV_W > NW) ? NV_W : NW) + 1;
  localparam int OW  = ((NW > POS_W + 1) ? NW : POS_W + 1) + 3;
  localparam int PW  = 2 * OW;
  localparam int AW  = PW + 3;
  localparam logic [CMW-1:0] MAXV = CMW'(MAX_VERTICES);

  state_t      state;
  state_t      state_next;
  prod_step_t  step;
  logic [NV_W-1:0] num_vertices;

  // captured pair
  logic signed [OW-1:0] d1_r;
  logic signed [OW-1:0] d2_r;
  logic                 item_last;

  // set-up values
  logic signed [OW-1:0] n_r;
  logic signed [OW-1:0] ns_r;
  logic                 c1_r;
  logic                 c2_r;
  logic                 eq_r;

  // polynomial accumulators and shared multiplier
  logic signed [AW-1:0] alpha_acc;
  logic signed [AW-1:0] beta_acc;
  logic signed [OW-1:0] mul_x;
  logic signed [OW-1:0] mul_y;
  logic                 mul_dbl;
  logic                 mul_alpha;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] prod;
  logic                 prod_vld;
  logic                 prod_dbl;
  logic                 prod_alpha;
  logic signed [AW-1:0] acc_add;

  // sum state
  logic [SUM_W-1:0] running_sum;
  logic             zero_flag;
  logic             use_div;

  logic [POS_W-1:0] len_a;
  logic [POS_W-1:0] len_b;
  logic [CMW-1:0]   nv_ext;
  logic [CMW-1:0]   n_w;
  logic signed [OW-1:0] n_s;
  logic signed [OW-1:0] ns_s;
  logic                 c1_s;
  logic signed [AW-1:0] ns_ext;
  logic signed [AW-1:0] d1_ext;
  logic signed [AW-1:0] beta_init;
  logic signed [OW-1:0] nd1;
  logic signed [OW-1:0] nd2;

  logic             beta_pos;
  logic [AW-1:0]    div_a;
  logic [AW-1:0]    div_b;
  logic             div_start;
  div_status_t      div_status;
  logic [SUM_W-1:0] div_q;
  logic [SUM_W-1:0] addend;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_new;
  logic             out_load;

  // edge lengths
  assign len_a = (in_data.pos_a1 < in_data.pos_a2) ? in_data.pos_a2 - in_data.pos_a1
                                                   : in_data.pos_a1 - in_data.pos_a2;
  assign len_b = (in_data.pos_b1 < in_data.pos_b2) ? in_data.pos_b2 - in_data.pos_b1
                                                   : in_data.pos_b1 - in_data.pos_b2;

  // clamped vertex count and case conditions
  assign nv_ext    = CMW'(num_vertices);
  assign n_w       = (nv_ext < MAXV) ? nv_ext : MAXV;
  assign n_s       = signed'({{(OW - CMW){1'b0}}, n_w});
  assign ns_s      = n_s - (d1_r + d2_r);
  assign c1_s      = !ns_s[OW-1] && (ns_s != '0);
  assign ns_ext    = AW'(ns_s);
  assign d1_ext    = AW'(d1_r);
  // linear part of beta when n > s: 3(s-n) - d1, plus -5(n-s) for unequal lengths
  assign beta_init = !c1_s ? '0
                   : (d1_r == d2_r) ? -((ns_ext <<< 1) + ns_ext) - d1_ext
                                    : -(ns_ext <<< 3) - d1_ext;

  assign nd1 = n_r - d1_r;
  assign nd2 = n_r - d2_r;

  // operand selection for the shared multiplier
  always_comb begin
    mul_x     = '0;
    mul_y     = '0;
    mul_dbl   = 1'b0;
    mul_alpha = 1'b0;
    case (step)
      P_ALPHA_MAIN: begin
        mul_alpha = 1'b1;
        if (c1_r) begin
          mul_x   = d1_r - OW'(1);
          mul_y   = ns_r;
          mul_dbl = 1'b1;
        end else begin
          mul_x = nd2;
          mul_y = nd2 - OW'(1);
        end
      end
      P_ALPHA_SQ: begin
        mul_alpha = 1'b1;
        if (c1_r) begin
          mul_x = d1_r;
          mul_y = d1_r - OW'(1);
        end
      end
      P_BETA_HEAD: begin
        mul_x = nd2;
        mul_y = c1_r ? nd2 : nd2 - OW'(1);
      end
      P_BETA_MID: begin
        if (c1_r) begin
          mul_x = eq_r ? n_r : nd1;
          mul_y = eq_r ? n_r - OW'(3) : nd1;
        end
      end
      P_BETA_TAIL: begin
        if (c1_r) begin
          mul_x = eq_r ? d1_r : d2_r;
          mul_y = eq_r ? OW'(6) - (n_r <<< 1) : -d2_r;
        end
      end
      P_BETA_LAST: begin
        if (eq_r) begin
          mul_x = c2_r ? d1_r : -nd1;
          mul_y = c2_r ? d1_r - OW'(1) : OW'(1) - nd1;
        end else begin
          mul_x = c2_r ? d1_r : -nd2;
          mul_y = c2_r ? (d2_r <<< 1) - d1_r - OW'(3)
                       : (d1_r <<< 1) - d2_r - n_r + OW'(3);
        end
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p   = PW'(mul_x) * PW'(mul_y);
  assign acc_add = prod_dbl ? (AW'(prod) <<< 1) : AW'(prod);

  // division operands: alpha clipped at zero, beta halved
  assign beta_pos = !beta_acc[AW-1] && (beta_acc[AW-1:1] != '0);
  assign div_a    = alpha_acc[AW-1] ? '0 : alpha_acc;
  assign div_b    = {1'b0, beta_acc[AW-1:1]};

  pca_divider #(
    .AW           (AW),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_a),
    .divisor (div_b),
    .status  (div_status),
    .quotient(div_q)
  );

  // saturating sum
  assign addend   = use_div ? div_q : '0;
  assign sum_wide = {1'b0, running_sum} + {1'b0, addend};
  assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (step == P_BETA_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        div_start  = beta_pos;
        state_next = beta_pos ? S_DIV : S_ADD;
      end
      S_DIV: begin
        if (div_status.done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        out_load = item_last && (!out_valid || !out_stall);
        if (!item_last || out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NV_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      num_vertices <= cfg_data;
    end
  end

  // pair capture, set-up and product accumulation
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      d1_r      <= OW'((len_a <= len_b) ? len_a : len_b);
      d2_r      <= OW'((len_a <= len_b) ? len_b : len_a);
      item_last <= in_data.last_pair;
    end
    if (state == S_SETUP) begin
      n_r       <= n_s;
      ns_r      <= ns_s;
      c1_r      <= c1_s;
      c2_r      <= !ns_s[OW-1];
      eq_r      <= (d1_r == d2_r);
      alpha_acc <= '0;
      beta_acc  <= beta_init;
      step      <= P_ALPHA_MAIN;
    end else begin
      if (state == S_MUL) begin
        step <= prod_step_t'(step + 3'd1);
      end
      if (prod_vld) begin
        if (prod_alpha) begin
          alpha_acc <= alpha_acc + acc_add;
        end else begin
          beta_acc <= beta_acc + acc_add;
        end
      end
    end
    prod       <= mul_p;
    prod_dbl   <= mul_dbl;
    prod_alpha <= mul_alpha;
    if (state == S_CHECK) begin
      use_div <= beta_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == S_MUL);
    end
  end

  // running sum, flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      zero_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_CHECK && !beta_pos) begin
        zero_flag <= 1'b1;
      end
      if (state == S_ADD) begin
        if (!item_last) begin
          running_sum <= sum_new;
        end else if (out_load) begin
          running_sum <= '0;
          zero_flag   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.expected_crossings    <= sum_new;
      out_data.zero_denominator_seen <= zero_flag;
    end
  end

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking a pair");

  a_divider_in_div: assert property (@(posedge clk) disable iff (rst)
    (div_status.busy || div_status.done) |-> (state == S_DIV))
    else $error("divider active outside the divide state");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ADD && item_last))
    else $error("result raised without a last pair");
`endif

endmodule

`default_nettype wire
